>>> rtl/core/sctf_pkg.sv
// ----------------------------------------------------------------------------
// SIP client transaction table package
// Types, codes and constants shared by the transaction table modules.
// ----------------------------------------------------------------------------
package sctf_pkg;

  localparam int unsigned NUM_ENTRIES = 32;
  localparam int unsigned IdxW        = $clog2(NUM_ENTRIES);
  localparam int unsigned MsW         = 18;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 17;

  localparam logic [15:0] BASE_RESET       = 16'd500;
  localparam logic [16:0] INV_LIMIT_RESET  = 17'd32000;
  localparam logic [16:0] OTH_LIMIT_RESET  = 17'd32000;
  localparam logic [16:0] INV_LINGER_RESET = 17'd45000;
  localparam logic [16:0] OTH_LINGER_RESET = 17'd5000;

  localparam logic [2:0] CLS_PROVISIONAL = 3'd1;
  localparam logic [2:0] CLS_SUCCESS     = 3'd2;

  typedef enum logic [1:0] {
    OP_START_INVITE = 2'd0,
    OP_START_OTHER  = 2'd1,
    OP_RESPONSE     = 2'd2,
    OP_TIMER        = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FREE  = 2'd1,
    STAT_INACTIVE = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    ENT_FREE       = 3'd0,
    ENT_CALLING    = 3'd1,
    ENT_TRYING     = 3'd2,
    ENT_PROCEEDING = 3'd3,
    ENT_COMPLETED  = 3'd4
  } ent_e;

  typedef enum logic [2:0] {
    CFG_BASE       = 3'd0,
    CFG_INV_LIMIT  = 3'd1,
    CFG_OTH_LIMIT  = 3'd2,
    CFG_INV_LINGER = 3'd3,
    CFG_OTH_LINGER = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_LOOKUP,
    FSM_EXEC
  } fsm_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [4:0] entry_index;
    logic [2:0] response_class;
  } req_t;

  typedef struct packed {
    logic [4:0]     result_index;
    logic [1:0]     status;
    logic           pass_to_user;
    logic           send_request;
    logic           send_ack;
    logic           timed_out;
    logic           timer_stop;
    logic           timer_start;
    logic [MsW-1:0] timer_ms;
    logic           entry_freed;
  } rsp_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_t;

  typedef struct packed {
    logic [15:0] base_interval_ms;
    logic [16:0] invite_retry_limit_ms;
    logic [16:0] other_retry_limit_ms;
    logic [16:0] invite_linger_ms;
    logic [16:0] other_linger_ms;
  } cfg_regs_t;

  typedef struct packed {
    ent_e           st;
    logic           is_invite;
    logic [MsW-1:0] interval;
  } entry_t;

endpackage

>>> rtl/core/sctf_if.sv
// ----------------------------------------------------------------------------
// SIP client transaction table channels
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface sctf_req_if;
  logic            valid;
  logic            ready;
  sctf_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sctf_rsp_if;
  logic            valid;
  logic            ready;
  sctf_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sctf_cfg_if;
  logic            valid;
  logic            ready;
  sctf_pkg::cfg_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/sctf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sctf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/sctf_cfg.sv
// ----------------------------------------------------------------------------
// SIP client transaction table configuration registers
// Holds the timer intervals and limits written over the configuration channel.
// ----------------------------------------------------------------------------
module sctf_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  sctf_cfg_if.sink            cfg_i,
  output sctf_pkg::cfg_regs_t regs_o
);

  sctf_pkg::cfg_regs_t regs_q, regs_d;

  assign cfg_i.ready = 1'b1;
  assign regs_o      = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      case (cfg_i.data.index)
        sctf_pkg::CFG_BASE:       regs_d.base_interval_ms      = cfg_i.data.wdata[15:0];
        sctf_pkg::CFG_INV_LIMIT:  regs_d.invite_retry_limit_ms = cfg_i.data.wdata;
        sctf_pkg::CFG_OTH_LIMIT:  regs_d.other_retry_limit_ms  = cfg_i.data.wdata;
        sctf_pkg::CFG_INV_LINGER: regs_d.invite_linger_ms      = cfg_i.data.wdata;
        sctf_pkg::CFG_OTH_LINGER: regs_d.other_linger_ms       = cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.base_interval_ms      <= sctf_pkg::BASE_RESET;
      regs_q.invite_retry_limit_ms <= sctf_pkg::INV_LIMIT_RESET;
      regs_q.other_retry_limit_ms  <= sctf_pkg::OTH_LIMIT_RESET;
      regs_q.invite_linger_ms      <= sctf_pkg::INV_LINGER_RESET;
      regs_q.other_linger_ms       <= sctf_pkg::OTH_LINGER_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

>>> rtl/core/sip_client_transaction_fsm.sv
// ----------------------------------------------------------------------------
// SIP client transaction table
// Drives INVITE and non-INVITE client transactions through their state machines.
// ----------------------------------------------------------------------------
// Each transaction returns exactly one result. A start scans the free map one
// entry per cycle from a rotating pointer until it finds a free entry or has
// checked them all; a response or timer event reads the entry record from the
// table memory in the lookup state and acts on it in the exec state, or ends
// in the lookup state when the addressed entry is not active.
// The block takes one transaction at a time, and a result waiting in the output
// register holds the block only when the next result is ready to replace it.
module sip_client_transaction_fsm (
  input  logic       clk_i,
  input  logic       rst_ni,
  sctf_req_if.sink   req_i,
  sctf_rsp_if.source rsp_o,
  sctf_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = sctf_pkg::IdxW;
  localparam int unsigned N    = sctf_pkg::NUM_ENTRIES;

  sctf_pkg::cfg_regs_t regs;
  sctf_pkg::fsm_e      state_q, state_d;
  sctf_pkg::req_t      req_q;
  sctf_pkg::rsp_t      rsp_q, rsp_d;
  sctf_pkg::entry_t    rec, wr_rec;
  logic                rsp_vld_q;
  logic [N-1:0]        free_q, free_d;
  logic [IdxW-1:0]     ptr_q, ptr_d, cnt_q, cnt_d, search_q, search_d, ptr_inc;
  logic [IdxW-1:0]     wr_addr, ent_idx;
  logic                we, fin, slot_free, inactive, alloc;
  logic [sctf_pkg::MsW-1:0] dbl;
  logic [16:0]         limit;
  logic [$bits(sctf_pkg::entry_t)-1:0] rd_data;

  sctf_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  sctf_ram #(
    .WIDTH ($bits(sctf_pkg::entry_t)),
    .DEPTH (N)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_addr),
    .wdata_i (wr_rec),
    .raddr_i (ent_idx),
    .rdata_o (rd_data)
  );

  assign rec       = sctf_pkg::entry_t'(rd_data);
  assign ent_idx   = IdxW'(req_q.entry_index);
  assign slot_free = !rsp_vld_q || rsp_o.ready;
  assign inactive  = (32'(req_q.entry_index) >= N) || free_q[ent_idx];
  assign ptr_inc   = (ptr_q == IdxW'(N - 1)) ? '0 : ptr_q + 1'b1;
  assign dbl       = {rec.interval[sctf_pkg::MsW-2:0], 1'b0};
  assign limit     = rec.is_invite ? regs.invite_retry_limit_ms : regs.other_retry_limit_ms;

  assign req_i.ready = (state_q == sctf_pkg::FSM_IDLE);
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    cnt_d    = cnt_q;
    search_d = search_q;
    free_d   = free_q;
    rsp_d    = '0;
    wr_rec   = rec;
    wr_addr  = ent_idx;
    we       = 1'b0;
    fin      = 1'b0;
    alloc    = 1'b0;
    rsp_d.result_index = req_q.entry_index;
    rsp_d.status       = sctf_pkg::STAT_OK;

    case (state_q)
      sctf_pkg::FSM_IDLE: begin
        if (req_i.valid) begin
          ptr_d = search_q;
          cnt_d = '0;
          if (req_i.data.operation == sctf_pkg::OP_START_INVITE ||
              req_i.data.operation == sctf_pkg::OP_START_OTHER) begin
            state_d = sctf_pkg::FSM_SCAN;
          end else begin
            state_d = sctf_pkg::FSM_LOOKUP;
          end
        end
      end

      sctf_pkg::FSM_SCAN: begin
        if (free_q[ptr_q]) begin
          rsp_d.result_index = 5'(ptr_q);
          rsp_d.send_request = 1'b1;
          rsp_d.timer_start  = 1'b1;
          rsp_d.timer_ms     = sctf_pkg::MsW'(regs.base_interval_ms);
          wr_rec.is_invite   = (req_q.operation == sctf_pkg::OP_START_INVITE);
          wr_rec.st          = wr_rec.is_invite ? sctf_pkg::ENT_CALLING
                                                : sctf_pkg::ENT_TRYING;
          wr_rec.interval    = sctf_pkg::MsW'(regs.base_interval_ms);
          wr_addr            = ptr_q;
          if (slot_free) begin
            fin            = 1'b1;
            alloc          = 1'b1;
            we             = 1'b1;
            free_d[ptr_q]  = 1'b0;
            search_d       = ptr_inc;
          end
        end else if (cnt_q == IdxW'(N - 1)) begin
          rsp_d.result_index = '0;
          rsp_d.status       = sctf_pkg::STAT_NO_FREE;
          fin                = slot_free;
        end else begin
          ptr_d = ptr_inc;
          cnt_d = cnt_q + 1'b1;
        end
      end

      sctf_pkg::FSM_LOOKUP: begin
        if (inactive) begin
          rsp_d.status = sctf_pkg::STAT_INACTIVE;
          fin          = slot_free;
        end else begin
          state_d = sctf_pkg::FSM_EXEC;
        end
      end

      sctf_pkg::FSM_EXEC: begin
        if (rec.is_invite) begin
          case (rec.st)
            sctf_pkg::ENT_CALLING: begin
              if (req_q.operation == sctf_pkg::OP_RESPONSE) begin
                rsp_d.pass_to_user = 1'b1;
                rsp_d.timer_stop   = 1'b1;
                if (req_q.response_class == sctf_pkg::CLS_PROVISIONAL) begin
                  wr_rec.st = sctf_pkg::ENT_PROCEEDING;
                  we        = 1'b1;
                end else if (req_q.response_class == sctf_pkg::CLS_SUCCESS) begin
                  rsp_d.entry_freed = 1'b1;
                end else begin
                  rsp_d.send_ack    = 1'b1;
                  rsp_d.timer_start = 1'b1;
                  rsp_d.timer_ms    = sctf_pkg::MsW'(regs.invite_linger_ms);
                  wr_rec.st         = sctf_pkg::ENT_COMPLETED;
                  we                = 1'b1;
                end
              end else begin
                wr_rec.interval = dbl;
                we              = 1'b1;
                if (dbl > {1'b0, limit}) begin
                  rsp_d.timed_out   = 1'b1;
                  rsp_d.entry_freed = 1'b1;
                end else begin
                  rsp_d.send_request = 1'b1;
                  rsp_d.timer_start  = 1'b1;
                  rsp_d.timer_ms     = dbl;
                end
              end
            end
            sctf_pkg::ENT_PROCEEDING: begin
              if (req_q.operation == sctf_pkg::OP_RESPONSE) begin
                rsp_d.pass_to_user = 1'b1;
                if (req_q.response_class == sctf_pkg::CLS_SUCCESS) begin
                  rsp_d.entry_freed = 1'b1;
                end else if (req_q.response_class != sctf_pkg::CLS_PROVISIONAL) begin
                  rsp_d.send_ack    = 1'b1;
                  rsp_d.timer_start = 1'b1;
                  rsp_d.timer_ms    = sctf_pkg::MsW'(regs.invite_linger_ms);
                  wr_rec.st         = sctf_pkg::ENT_COMPLETED;
                  we                = 1'b1;
                end
              end
            end
            default: begin
              if (req_q.operation == sctf_pkg::OP_RESPONSE) begin
                rsp_d.send_ack = 1'b1;
              end else begin
                rsp_d.entry_freed = 1'b1;
              end
            end
          endcase
        end else begin
          case (rec.st) inside
            sctf_pkg::ENT_TRYING, sctf_pkg::ENT_PROCEEDING: begin
              if (req_q.operation == sctf_pkg::OP_RESPONSE) begin
                rsp_d.pass_to_user = 1'b1;
                we                 = 1'b1;
                if (req_q.response_class == sctf_pkg::CLS_PROVISIONAL) begin
                  wr_rec.st = sctf_pkg::ENT_PROCEEDING;
                end else begin
                  wr_rec.st         = sctf_pkg::ENT_COMPLETED;
                  rsp_d.timer_stop  = 1'b1;
                  rsp_d.timer_start = 1'b1;
                  rsp_d.timer_ms    = sctf_pkg::MsW'(regs.other_linger_ms);
                end
              end else begin
                wr_rec.interval = dbl;
                we              = 1'b1;
                if (dbl > {1'b0, limit}) begin
                  rsp_d.timed_out   = 1'b1;
                  rsp_d.entry_freed = 1'b1;
                end else begin
                  rsp_d.send_request = 1'b1;
                  rsp_d.timer_start  = 1'b1;
                  rsp_d.timer_ms     = dbl;
                end
              end
            end
            default: begin
              if (req_q.operation == sctf_pkg::OP_TIMER) begin
                rsp_d.entry_freed = 1'b1;
              end
            end
          endcase
        end
        fin = slot_free;
        if (!slot_free) begin
          we = 1'b0;
        end else if (rsp_d.entry_freed) begin
          free_d[ent_idx] = 1'b1;
        end
      end

      default: state_d = sctf_pkg::FSM_IDLE;
    endcase

    if (fin) begin
      state_d = sctf_pkg::FSM_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sctf_pkg::FSM_IDLE;
      free_q    <= '1;
      search_q  <= '0;
      ptr_q     <= '0;
      cnt_q     <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      free_q   <= free_d;
      search_q <= search_d;
      ptr_q    <= ptr_d;
      cnt_q    <= cnt_d;
      if (fin) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      req_q <= req_i.data;
    end
    if (fin) begin
      rsp_q <= rsp_d;
    end
  end

  // A start reports no free entry only when every entry is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && rsp_d.status == sctf_pkg::STAT_NO_FREE) |-> (free_q == '0))
    else $error("no free entry reported while an entry is free");

  // An allocated entry is marked busy after the allocation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc |=> !free_q[$past(ptr_q)])
    else $error("allocated entry still marked free");

  // A result never both restarts the timer and frees the entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> !(rsp_d.timer_start && rsp_d.entry_freed))
    else $error("timer started on a freed entry");

endmodule
